@@ src/eos_pkg.sv @@
`timescale 1ns / 1ps

package eos_pkg;

  localparam int unsigned ButtonW  = 12;
  localparam int unsigned FloorSelW = 2;
  localparam int unsigned DirW     = 2;
  localparam int unsigned PendingW = 10;

  typedef enum logic [DirW-1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // one poll word
  typedef struct packed {
    logic [ButtonW-1:0]   button_levels;
    logic [FloorSelW-1:0] current_floor;
    logic [FloorSelW-1:0] between_position;
    logic [DirW-1:0]      travel_direction;
    logic                 clear_here;
    logic                 clear_every;
  } in_t;

  // one result word
  typedef struct packed {
    logic [PendingW-1:0] pending_orders;
    logic [DirW-1:0]     chosen_direction;
    logic                stop_here;
    logic                floor_has_order;
  } out_t;

endpackage

@@ src/eos_step.sv @@
`timescale 1ns / 1ps

module eos_step #(
  parameter int unsigned FLOOR_COUNT = 4
) (
  input  logic [3*FLOOR_COUNT-3:0] order_i,
  input  eos_pkg::in_t             item_i,
  output logic [3*FLOOR_COUNT-3:0] order_o,
  output eos_pkg::out_t            result_o
);
  import eos_pkg::*;

  // per-floor groups {up, inside, down}; the missing slots at the end floors stay zero
  localparam int unsigned ExtW   = 3 * FLOOR_COUNT;
  localparam int unsigned BtnW   = (ExtW > ButtonW) ? ExtW : ButtonW;
  localparam int unsigned FloorW = $clog2(FLOOR_COUNT);
  localparam int unsigned Top    = FLOOR_COUNT - 1;
  localparam logic [FloorW-1:0] TopFloor = FloorW'(FLOOR_COUNT - 1);

  logic [ExtW-1:0]        cur_ext;
  logic [ExtW-1:0]        next_ext;
  logic [BtnW-1:0]        btn;
  logic [FloorW-1:0]      cur;
  logic [FloorW-1:0]      betw;
  logic [FloorW-1:0]      bt_lo;
  logic [2:0]             grp [FLOOR_COUNT];
  logic [FLOOR_COUNT-1:0] occ;
  logic [2:0]             here;
  logic                   above_cur, below_cur, above_bt, below_bt;
  logic                   above_sel, below_sel;
  logic                   stop;
  dir_e                   dir;
  dir_e                   chosen;

  // saturate floor indexes to the top floor
  assign cur  = (32'(item_i.current_floor) > Top) ? TopFloor : FloorW'(item_i.current_floor);
  assign betw = (32'(item_i.between_position) > Top) ? TopFloor
                                                      : FloorW'(item_i.between_position);
  assign bt_lo = betw - FloorW'(1);

  // direction code 3 behaves as stop
  always_comb begin
    case (item_i.travel_direction)
      DIR_UP:   dir = DIR_UP;
      DIR_DOWN: dir = DIR_DOWN;
      default:  dir = DIR_STOP;
    endcase
  end

  // order update: clear all, or set from buttons then optionally clear current floor
  always_comb begin
    cur_ext  = {1'b0, order_i, 1'b0};
    btn      = BtnW'(item_i.button_levels);
    next_ext = cur_ext;
    if (item_i.clear_every) begin
      next_ext = '0;
    end else begin
      for (int f = 0; f < FLOOR_COUNT; f++) begin
        if (btn[3*f]) next_ext[3*f+1] = 1'b1;
        if (btn[3*f+1] && (f < FLOOR_COUNT - 1)) next_ext[3*f+2] = 1'b1;
        if (btn[3*f+2] && (f > 0)) next_ext[3*f] = 1'b1;
        if (item_i.clear_here && (FloorW'(f) == cur)) next_ext[3*f +: 3] = 3'b000;
      end
    end
  end

  assign order_o = next_ext[ExtW-2:1];

  always_comb begin
    for (int g = 0; g < FLOOR_COUNT; g++) begin
      grp[g] = next_ext[3*g +: 3];
      occ[g] = |next_ext[3*g +: 3];
    end
  end

  // orders strictly above / below a floor
  always_comb begin
    above_cur = 1'b0;
    below_cur = 1'b0;
    above_bt  = 1'b0;
    below_bt  = 1'b0;
    for (int g = 0; g < FLOOR_COUNT; g++) begin
      above_cur = above_cur | (occ[g] & (FloorW'(g) > cur));
      below_cur = below_cur | (occ[g] & (FloorW'(g) < cur));
      above_bt  = above_bt  | (occ[g] & (FloorW'(g) > bt_lo));
      below_bt  = below_bt  | (occ[g] & (FloorW'(g) < betw));
    end
  end

  assign above_sel = (betw != '0) ? above_bt : above_cur;
  assign below_sel = (betw != '0) ? below_bt : below_cur;

  always_comb begin
    if (next_ext == '0) begin
      chosen = DIR_STOP;
    end else if (above_sel && !below_sel) begin
      chosen = DIR_UP;
    end else if (!above_sel && below_sel) begin
      chosen = DIR_DOWN;
    end else if (dir == DIR_STOP) begin
      chosen = DIR_DOWN;
    end else begin
      chosen = dir;
    end
  end

  assign here = grp[cur];

  assign stop = ((dir == DIR_DOWN) && (cur == '0))
             || ((dir == DIR_UP) && (cur == TopFloor))
             || here[1]
             || (here[2] && (dir == DIR_UP))
             || (here[0] && (dir == DIR_DOWN))
             || ((dir == DIR_UP) && !above_cur)
             || ((dir == DIR_DOWN) && !below_cur);

  assign result_o.pending_orders   = PendingW'(order_o);
  assign result_o.chosen_direction = chosen;
  assign result_o.stop_here        = stop;
  assign result_o.floor_has_order  = |here;

endmodule

@@ src/elevator_order_scheduler.sv @@
`timescale 1ns / 1ps

// Order book and direction logic for one car. Every accepted poll word updates
// the stored order bits (clear all, or set from the buttons and then optionally
// clear the current floor) and yields one result word: the order/lamp vector,
// the next direction, the stop decision and whether the current floor holds an
// order. One word is accepted per clock while in_stall_o is low; the word is
// loaded into the input register when it is accepted, and its result word
// becomes valid when it moves on into the result register, the order update
// and all decisions being one pass of logic between the two. While the output
// is stalled the result register holds and one more word can wait in the
// input register, after which the input stalls. The order bits are updated
// when a word moves into the result register, so back-to-back words see
// each other's orders in sequence. FLOOR_COUNT sets the size of the order
// store (3 * FLOOR_COUNT - 2 bits); pending_orders shows its low ten bits.
module elevator_order_scheduler_core #(
  parameter int unsigned FLOOR_COUNT = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  eos_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output eos_pkg::out_t out_word_o
);
  import eos_pkg::*;

  localparam int unsigned OrderW = 3 * FLOOR_COUNT - 2;

  // input register
  logic  s1_valid_q, s1_valid_d;
  in_t   s1_q;
  // result register
  logic  out_valid_q, out_valid_d;
  out_t  out_q;
  // order store
  logic [OrderW-1:0] order_q, order_d;

  logic [OrderW-1:0] next_order;
  out_t              step_result;
  logic              in_accept;
  logic              advance;

  // a word moves on when the result register is empty or being drained
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  eos_step #(
    .FLOOR_COUNT(FLOOR_COUNT)
  ) u_step (
    .order_i (order_q),
    .item_i  (s1_q),
    .order_o (next_order),
    .result_o(step_result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    order_d = advance ? next_order : order_q;
  end

  // control state and order store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      order_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      order_q     <= order_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_word_i;
    end
    if (advance) begin
      out_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // order bits only move together with a word
  a_order_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(order_q))
    else $error("order store changed without a word advancing");

  // clear all leaves no pending order
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_q.clear_every) |=> (out_word_o.pending_orders == '0))
    else $error("clear all left pending orders");

  // an empty result register never blocks the input register
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |-> !in_stall_o)
    else $error("input stalled while result register empty");

  // a drained result with nothing behind it empties the output
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !s1_valid_q) |=> !out_valid_o)
    else $error("result word repeated");

  // no orders means the car stops
  a_idle_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (next_order == '0)) |=> (out_word_o.chosen_direction == DIR_STOP))
    else $error("direction chosen with no orders");

endmodule
